/* rtl/erd_pkg.sv */
// Shared types and constants for the escape-byte run-length row decoder.
// No dependencies; imported by every module of the block.
package erd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_IMAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE    = 2'd3;

  // Register reset values
  localparam logic [9:0]  RST_PIXELS_PER_ROW = 10'd320;
  localparam logic [9:0]  RST_ROWS_PER_IMAGE = 10'd200;
  localparam logic [15:0] RST_MAX_ROW_BYTES  = 16'd960;
  localparam logic [7:0]  RST_ESCAPE_CODE    = 8'hF0;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [9:0]  pixels_per_row;
    logic [9:0]  rows_per_image;
    logic [15:0] max_row_bytes;
    logic [7:0]  escape_code;
  } cfg_t;

  typedef struct packed {
    logic       status;
    logic       image_done;
    logic       row_done;
    logic [9:0] row_index;
    logic [9:0] x_start;
    logic [7:0] run_count;
    logic [7:0] pixel_value;
  } res_t;

endpackage

/* rtl/erd_core.sv */
// Decode state and per-byte next-state logic of the row decoder.
// Depends on erd_pkg (cfg_t, res_t, status codes).
module erd_core import erd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] stream_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_HDR_LO  = 3'd0;
  localparam logic [2:0] PH_HDR_HI  = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_ESC_LEN = 3'd3;
  localparam logic [2:0] PH_ESC_VAL = 3'd4;
  localparam logic [2:0] PH_ERROR   = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  hdr_lo_r, hdr_lo_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [9:0]  pix_left_r, pix_left_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [9:0]  row_r, row_nxt;
  logic [7:0]  held_len_r, held_len_nxt;
  logic        skip_r, skip_nxt;

  logic [15:0] count;
  logic [15:0] bl_dec;
  logic        last;
  logic        data_ph;
  logic        emit;
  logic [9:0]  run10;
  logic [9:0]  next_row;

  assign count    = {stream_byte, hdr_lo_r};
  assign bl_dec   = bytes_left_r - 16'd1;
  assign last     = (bl_dec == 16'd0);
  assign run10    = ({2'b00, held_len_r} < pix_left_r) ? {2'b00, held_len_r} : pix_left_r;
  assign next_row = row_r + 10'd1;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_lo_nxt     = hdr_lo_r;
    bytes_left_nxt = bytes_left_r;
    pix_left_nxt   = pix_left_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    held_len_nxt   = held_len_r;
    skip_nxt       = skip_r;
    data_ph        = 1'b0;
    emit           = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    res.x_start    = col_r;
    res.row_index  = row_r;
    res.status     = STATUS_OK;

    if (step) begin
      case (phase_r)
        PH_ERROR: begin
          res_valid   = 1'b1;
          res.x_start = '0;
          res.status  = STATUS_ERR;
        end
        PH_HDR_LO: begin
          hdr_lo_nxt = stream_byte;
          phase_nxt  = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          if (count == 16'd0 || count > cfg.max_row_bytes) begin
            phase_nxt   = PH_ERROR;
            res_valid   = 1'b1;
            res.x_start = '0;
            res.status  = STATUS_ERR;
          end else begin
            bytes_left_nxt = count;
            pix_left_nxt   = cfg.pixels_per_row;
            col_nxt        = '0;
            skip_nxt       = 1'b0;
            held_len_nxt   = '0;
            phase_nxt      = PH_DATA;
          end
        end
        PH_DATA: begin
          data_ph = 1'b1;
          if (!skip_r && pix_left_r != 10'd0) begin
            if (stream_byte != cfg.escape_code) begin
              emit            = 1'b1;
              res.pixel_value = stream_byte;
              res.run_count   = 8'd1;
              col_nxt         = col_r + 10'd1;
              pix_left_nxt    = pix_left_r - 10'd1;
            end else if (bl_dec < 16'd2) begin
              skip_nxt = 1'b1;
            end else begin
              phase_nxt = PH_ESC_LEN;
            end
          end
        end
        PH_ESC_LEN: begin
          data_ph      = 1'b1;
          held_len_nxt = stream_byte;
          phase_nxt    = PH_ESC_VAL;
        end
        PH_ESC_VAL: begin
          data_ph         = 1'b1;
          emit            = 1'b1;
          res.pixel_value = stream_byte;
          res.run_count   = run10[7:0];
          col_nxt         = col_r + run10;
          pix_left_nxt    = pix_left_r - run10;
          phase_nxt       = PH_DATA;
        end
        default: begin
          phase_nxt = PH_HDR_LO;
        end
      endcase

      if (data_ph) begin
        bytes_left_nxt = bl_dec;
        if (last) begin
          res.row_done = 1'b1;
          if (next_row >= cfg.rows_per_image || next_row == 10'd0) begin
            res.image_done = 1'b1;
            row_nxt        = '0;
          end else begin
            row_nxt = next_row;
          end
          phase_nxt = PH_HDR_LO;
          skip_nxt  = 1'b0;
        end
        res_valid = emit || last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR_LO;
      hdr_lo_r     <= '0;
      bytes_left_r <= '0;
      pix_left_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
      held_len_r   <= '0;
      skip_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_lo_r     <= hdr_lo_nxt;
      bytes_left_r <= bytes_left_nxt;
      pix_left_r   <= pix_left_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      held_len_r   <= held_len_nxt;
      skip_r       <= skip_nxt;
    end
  end

  // Error phase is left only by reset
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("decoder left the error phase");

  // An error result carries no pixels
  a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == STATUS_ERR) |-> (res.run_count == 8'd0 && !res.row_done))
    else $error("error result carries pixel data");

  // A run never writes more pixels than the row has left
  a_run_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == STATUS_OK) |-> ({2'b00, res.run_count} <= pix_left_r))
    else $error("run exceeds free pixels in row");

endmodule

/* rtl/erd_skid.sv */
// Two-entry output buffer for decoded results; upstream ready is registered.
// Depends on erd_pkg (res_t).
module erd_skid import erd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  res_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output res_t dn_data
);

  logic out_valid_r;
  res_t out_data_r;
  logic skid_valid_r;
  res_t skid_data_r;
  logic push;

  assign up_ready = !skid_valid_r;
  assign push     = up_valid && up_ready;
  assign dn_valid = out_valid_r;
  assign dn_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || dn_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || dn_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : up_data;
    end else if (push) begin
      skid_data_r <= up_data;
    end
  end

  // The spare entry fills only behind a waiting head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("spare entry valid with empty head");

  // A stalled head keeps its result
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !dn_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

/* rtl/escape_rle_row_image_decoder_top.sv */
// Top level of the escape-byte run-length row decoder: input register,
// configuration registers, decode core and output buffer. Depends on erd_pkg,
// erd_core and erd_skid.
//
// The decoder takes one compressed byte per item on in_* and may take one in
// every clock cycle. Each accepted byte is held in an input register and is
// decoded by the core once the output buffer has room. Phase, counters and
// row position update at the end of the cycle in which the byte is decoded.
// If the byte yields a result, the result lands in a two-entry output buffer
// at that same edge and appears on out_* from that buffer's head register.
// The core updates its state for each byte it decodes, so the decoder runs at
// one byte per cycle while out_tready stays high. The output buffer's spare
// entry keeps in_tready independent of out_tready in the same cycle; when the
// consumer stalls, the input side stops after the buffer fills. Literal bytes
// while the row has pixels left and the value byte of a run each give one
// result; run-length bytes give none, and header bytes give none unless they
// complete an invalid row byte count; the last byte of a row always gives one
// (row_done set). The byte that completes an invalid row byte count and every
// byte after it return an error result until reset.
// Write configuration only while idle; pixels_per_row and max_row_bytes act
// at the next row header, escape_code at once.
module escape_rle_row_image_decoder_top import erd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] stream_byte
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // [7:0] pixel_value, [15:8] run_count,
                                            // [25:16] x_start, [35:26] row_index
  output logic                  out_tlast,  // image_done
  output logic [1:0]            out_tuser,  // [0] row_done, [1] status
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       step;
  logic       buf_ready;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixels_per_row <= RST_PIXELS_PER_ROW;
      cfg_r.rows_per_image <= RST_ROWS_PER_IMAGE;
      cfg_r.max_row_bytes  <= RST_MAX_ROW_BYTES;
      cfg_r.escape_code    <= RST_ESCAPE_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXELS_PER_ROW: cfg_r.pixels_per_row <= cfg_data[9:0];
        CFG_ROWS_PER_IMAGE: cfg_r.rows_per_image <= cfg_data[9:0];
        CFG_MAX_ROW_BYTES:  cfg_r.max_row_bytes  <= cfg_data;
        CFG_ESCAPE_CODE:    cfg_r.escape_code    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register: advance into the core whenever the output buffer has room
  assign step      = s1_valid_r && buf_ready;
  assign in_tready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  erd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .stream_byte (s1_byte_r),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  erd_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (res_valid),
    .up_ready (buf_ready),
    .up_data  (res),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_res)
  );

  // Pack the result item onto the stream ports
  assign out_tdata = {4'b0000, out_res.row_index, out_res.x_start,
                      out_res.run_count, out_res.pixel_value};
  assign out_tlast = out_res.image_done;
  assign out_tuser = {out_res.status, out_res.row_done};

endmodule
